>>> rtl/rcc_pkg.sv
// Shared types, constants and microcode encodings for the Reno congestion and RTO controller.
package rcc_pkg;

    localparam int SEQ_BITS = 32;
    localparam int UADDR_BITS = 5;

    typedef logic [SEQ_BITS-1:0]   t_seq;
    typedef logic [UADDR_BITS-1:0] t_uaddr;

    // Event kinds carried in the mode field
    localparam logic [1:0] MODE_SENT  = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_TIMER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MSS   = 2'd0;
    localparam logic [1:0] CFG_FLOOR = 2'd1;
    localparam logic [1:0] CFG_CEIL  = 2'd2;

    localparam logic [15:0] MSS_RESET     = 16'd1460;
    localparam logic [23:0] FLOOR_RESET   = 24'd200;
    localparam logic [23:0] CEIL_RESET    = 24'd60000;
    localparam logic [31:0] CWND_RESET    = 32'd2920;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [23:0] RTO_RESET     = 24'd1000;
    localparam logic [3:0]  BACKOFF_LIMIT = 4'd12;
    localparam logic [25:0] RTO_MIN_MARGIN = 26'd10;
    localparam logic [7:0]  DUP_MAX       = 8'd255;
    localparam logic [7:0]  DUP_TRIGGER   = 8'd3;

    typedef struct packed {
        logic [1:0]  mode;
        t_seq        ack_number;
        logic [15:0] sent_length;
        logic [23:0] rtt_sample;
        logic        rtt_valid;
        logic        queue_nonempty;
    } t_in_item;

    typedef struct packed {
        logic [31:0] congestion_window;
        logic [31:0] slow_start_threshold;
        logic [23:0] timeout_ms;
        logic [23:0] smoothed_rtt_ms;
        logic [3:0]  backoff_count;
        logic        retransmit_now;
        logic        in_recovery;
    } t_out_item;

    typedef struct packed {
        logic [15:0] mss;
        logic [23:0] floor_ms;
        logic [23:0] ceil_ms;
    } t_cfg;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_START,
        UOP_ADV,
        UOP_RP_DIFF,
        UOP_EXIT_REC,
        UOP_SET_UNA,
        UOP_RTT_FIRST,
        UOP_RTT_DELTA,
        UOP_RTT_SMOOTH,
        UOP_RTO_SUM,
        UOP_RTO_CLAMP,
        UOP_DIV_START,
        UOP_DIV_STEP,
        UOP_CA_ADD,
        UOP_SS_ADD,
        UOP_DUP_INC,
        UOP_HALVE,
        UOP_FR_WIN,
        UOP_TO_HALVE,
        UOP_TO_WIN,
        UOP_TO_RTO,
        UOP_SEND
    } t_uop;

    // Branch conditions
    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_END,
        C_MODE_SENT,
        C_MODE_TIMER,
        C_MODE_NOT_ACK,
        C_NOT_ADV,
        C_TMP_LATE,
        C_RP_ZERO,
        C_NO_RTT,
        C_SRTT_SET,
        C_CWND_LT_SSTH,
        C_DIV_MORE,
        C_DUP_LT3,
        C_NO_QUEUE
    } t_cond;

    typedef struct packed {
        t_uop   op;
        t_cond  cond;
        t_uaddr target;
    } t_uword;

    // Datapath status used by branch conditions
    typedef struct packed {
        logic not_adv;
        logic tmp_late;
        logic rp_zero;
        logic srtt_set;
        logic cwnd_lt_ssth;
        logic div_more;
        logic dup_lt3;
    } t_flags;

endpackage

>>> rtl/rcc_ucode_rom.sv
// Microprogram read-only table: one control word per sequencer step.
module rcc_ucode_rom (
    input  rcc_pkg::t_uaddr i_addr,
    output rcc_pkg::t_uword o_word
);
    import rcc_pkg::*;

    localparam t_uaddr L_RP_CHK  = 5'd5;
    localparam t_uaddr L_UNA     = 5'd8;
    localparam t_uaddr L_RTT_UPD = 5'd11;
    localparam t_uaddr L_RTO     = 5'd13;
    localparam t_uaddr L_GROW    = 5'd15;
    localparam t_uaddr L_DIV     = 5'd17;
    localparam t_uaddr L_SS      = 5'd19;
    localparam t_uaddr L_DUP     = 5'd20;
    localparam t_uaddr L_TIMER   = 5'd25;
    localparam t_uaddr L_SENT    = 5'd29;
    localparam t_uaddr L_END     = 5'd30;

    // Decode step address into control word
    always_comb begin
        unique case (i_addr)
            // dispatch on event kind
            5'd0:  o_word = '{UOP_START,      C_MODE_SENT,    L_SENT};
            5'd1:  o_word = '{UOP_NOP,        C_MODE_TIMER,   L_TIMER};
            5'd2:  o_word = '{UOP_NOP,        C_MODE_NOT_ACK, L_END};
            // ACK: check advance
            5'd3:  o_word = '{UOP_ADV,        C_NEXT,         L_END};
            5'd4:  o_word = '{UOP_NOP,        C_NOT_ADV,      L_DUP};
            L_RP_CHK: o_word = '{UOP_RP_DIFF, C_RP_ZERO,      L_UNA};
            5'd6:  o_word = '{UOP_NOP,        C_TMP_LATE,     L_UNA};
            5'd7:  o_word = '{UOP_EXIT_REC,   C_NEXT,         L_END};
            // RTT estimator
            L_UNA: o_word = '{UOP_SET_UNA,    C_NO_RTT,       L_GROW};
            5'd9:  o_word = '{UOP_NOP,        C_SRTT_SET,     L_RTT_UPD};
            5'd10: o_word = '{UOP_RTT_FIRST,  C_JUMP,         L_RTO};
            L_RTT_UPD: o_word = '{UOP_RTT_DELTA, C_NEXT,      L_END};
            5'd12: o_word = '{UOP_RTT_SMOOTH, C_NEXT,         L_END};
            L_RTO: o_word = '{UOP_RTO_SUM,    C_NEXT,         L_END};
            5'd14: o_word = '{UOP_RTO_CLAMP,  C_NEXT,         L_END};
            // window growth
            L_GROW: o_word = '{UOP_NOP,       C_CWND_LT_SSTH, L_SS};
            5'd16: o_word = '{UOP_DIV_START,  C_NEXT,         L_END};
            L_DIV: o_word = '{UOP_DIV_STEP,   C_DIV_MORE,     L_DIV};
            5'd18: o_word = '{UOP_CA_ADD,     C_JUMP,         L_END};
            L_SS:  o_word = '{UOP_SS_ADD,     C_JUMP,         L_END};
            // duplicate ACK in recovery
            L_DUP: o_word = '{UOP_NOP,        C_RP_ZERO,      L_END};
            5'd21: o_word = '{UOP_DUP_INC,    C_NEXT,         L_END};
            5'd22: o_word = '{UOP_NOP,        C_DUP_LT3,      L_END};
            5'd23: o_word = '{UOP_HALVE,      C_NEXT,         L_END};
            5'd24: o_word = '{UOP_FR_WIN,     C_NEXT,         L_END};
            // timeout retransmit
            L_TIMER: o_word = '{UOP_NOP,      C_NO_QUEUE,     L_END};
            5'd26: o_word = '{UOP_TO_HALVE,   C_NEXT,         L_END};
            5'd27: o_word = '{UOP_TO_WIN,     C_NEXT,         L_END};
            5'd28: o_word = '{UOP_TO_RTO,     C_JUMP,         L_END};
            // sent event
            L_SENT: o_word = '{UOP_SEND,      C_JUMP,         L_END};
            L_END: o_word = '{UOP_NOP,        C_END,          L_END};
            default: o_word = '{UOP_NOP,      C_END,          L_END};
        endcase
    end

endmodule

>>> rtl/rcc_divider.sv
// Radix-2 restoring divider, one quotient bit per step.
module rcc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_step,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic [31:0] o_quotient,
    output logic        o_more
);
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic [32:0] n_shift;
    logic [32:0] n_trial;

    // Form the trial subtraction
    always_comb begin
        n_shift = {r_rem, r_quo[31]};
        n_trial = n_shift - {1'b0, r_den};
    end

    // Load operands or retire one quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (i_step && r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 32'd0;
            r_den <= i_divisor;
        end else if (i_step) begin
            if (!n_trial[32]) begin
                r_rem <= n_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= n_shift[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_more     = (r_cnt != 6'd1);

endmodule

>>> rtl/rcc_datapath.sv
// Connection state registers and the micro-operations that update them.
module rcc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcc_pkg::t_uop     i_op,
    input  rcc_pkg::t_in_item i_item,
    input  rcc_pkg::t_cfg     i_cfg,
    output rcc_pkg::t_flags   o_flags,
    output rcc_pkg::t_out_item o_state
);
    import rcc_pkg::*;

    logic [31:0] r_cwnd;
    logic [31:0] r_ssth;
    logic [7:0]  r_dup;
    t_seq        r_rp;
    t_seq        r_una;
    t_seq        r_next;
    logic [23:0] r_srtt;
    logic [23:0] r_var;
    logic [23:0] r_rto;
    logic [3:0]  r_backoff;
    logic        r_resent;
    logic [31:0] r_tmp;

    logic [31:0] n_halved;
    logic [31:0] n_two_mss;
    logic [17:0] n_three_mss;
    logic [25:0] n_var_sum;
    logic [26:0] n_srtt_sum;
    logic [25:0] n_margin;
    logic [26:0] n_rto_sum;
    logic [26:0] n_floored;
    logic [26:0] n_clamped;
    logic [23:0] n_prev;
    logic [24:0] n_doubled;
    logic [32:0] n_fr_sum;
    logic [32:0] n_ss_sum;
    logic [32:0] n_ca_sum;
    logic [31:0] n_sq;
    logic [31:0] n_den;
    logic [31:0] w_quo;
    logic        w_more;

    // Shared arithmetic for the micro-operations
    always_comb begin
        n_two_mss   = {15'd0, i_cfg.mss, 1'b0};
        n_halved    = ({1'b0, r_cwnd[31:1]} > n_two_mss) ? {1'b0, r_cwnd[31:1]} : n_two_mss;
        n_three_mss = {2'd0, i_cfg.mss} + {1'b0, i_cfg.mss, 1'b0};
        n_var_sum   = {2'd0, r_var} + {1'b0, r_var, 1'b0} + {2'd0, r_tmp[23:0]};
        n_srtt_sum  = {r_srtt, 3'd0} - {3'd0, r_srtt} + {3'd0, i_item.rtt_sample};
        n_margin    = ({r_var, 2'd0} < RTO_MIN_MARGIN) ? RTO_MIN_MARGIN : {r_var, 2'd0};
        n_rto_sum   = {3'd0, r_srtt} + {1'b0, n_margin};
        n_floored   = (r_tmp[26:0] < {3'd0, i_cfg.floor_ms}) ? {3'd0, i_cfg.floor_ms}
                                                             : r_tmp[26:0];
        n_clamped   = (n_floored > {3'd0, i_cfg.ceil_ms}) ? {3'd0, i_cfg.ceil_ms} : n_floored;
        n_prev      = (r_rto < i_cfg.floor_ms) ? i_cfg.floor_ms : r_rto;
        n_doubled   = {n_prev, 1'b0};
        n_fr_sum    = {1'b0, r_ssth} + {15'd0, n_three_mss};
        n_ss_sum    = {1'b0, r_cwnd} + {17'd0, i_cfg.mss};
        n_ca_sum    = {1'b0, r_cwnd} + {1'b0, w_quo};
        n_sq        = {16'd0, i_cfg.mss} * {16'd0, i_cfg.mss};
        n_den       = (r_cwnd == 32'd0) ? 32'd1 : r_cwnd;
    end

    rcc_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_op == UOP_DIV_START),
        .i_step     (i_op == UOP_DIV_STEP),
        .i_dividend (n_sq),
        .i_divisor  (n_den),
        .o_quotient (w_quo),
        .o_more     (w_more)
    );

    // Execute one micro-operation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd    <= CWND_RESET;
            r_ssth    <= ALL_ONES;
            r_dup     <= 8'd0;
            r_rp      <= '0;
            r_una     <= '0;
            r_next    <= '0;
            r_srtt    <= 24'd0;
            r_var     <= 24'd0;
            r_rto     <= RTO_RESET;
            r_backoff <= 4'd0;
            r_resent  <= 1'b0;
            r_tmp     <= 32'd0;
        end else begin
            case (i_op)
                UOP_START:      r_resent <= 1'b0;
                UOP_ADV:        r_tmp <= i_item.ack_number - r_una;
                UOP_RP_DIFF:    r_tmp <= i_item.ack_number - r_rp;
                UOP_EXIT_REC: begin
                    r_cwnd <= r_ssth;
                    r_rp   <= '0;
                    r_dup  <= 8'd0;
                end
                UOP_SET_UNA:    r_una <= i_item.ack_number;
                UOP_RTT_FIRST: begin
                    r_srtt <= i_item.rtt_sample;
                    r_var  <= {1'b0, i_item.rtt_sample[23:1]};
                end
                UOP_RTT_DELTA: begin
                    r_tmp <= (i_item.rtt_sample >= r_srtt)
                           ? {8'd0, i_item.rtt_sample - r_srtt}
                           : {8'd0, r_srtt - i_item.rtt_sample};
                end
                UOP_RTT_SMOOTH: begin
                    r_var  <= n_var_sum[25:2];
                    r_srtt <= n_srtt_sum[26:3];
                end
                UOP_RTO_SUM:    r_tmp <= {5'd0, n_rto_sum};
                UOP_RTO_CLAMP: begin
                    r_rto     <= n_clamped[23:0];
                    r_backoff <= 4'd0;
                end
                UOP_CA_ADD: begin
                    r_cwnd <= n_ca_sum[32] ? ALL_ONES : n_ca_sum[31:0];
                    r_dup  <= 8'd0;
                end
                UOP_SS_ADD: begin
                    r_cwnd <= (n_ss_sum > {1'b0, r_ssth}) ? r_ssth : n_ss_sum[31:0];
                    r_dup  <= 8'd0;
                end
                UOP_DUP_INC: begin
                    if (r_dup != DUP_MAX) begin
                        r_dup <= r_dup + 8'd1;
                    end
                end
                UOP_HALVE:      r_ssth <= n_halved;
                UOP_FR_WIN: begin
                    r_cwnd <= n_fr_sum[32] ? ALL_ONES : n_fr_sum[31:0];
                    r_rp   <= r_next;
                end
                UOP_TO_HALVE: begin
                    r_ssth <= n_halved;
                    r_rp   <= '0;
                    r_dup  <= 8'd0;
                end
                UOP_TO_WIN: begin
                    r_cwnd <= {16'd0, i_cfg.mss};
                    r_tmp  <= {7'd0, n_doubled};
                end
                UOP_TO_RTO: begin
                    r_rto    <= (r_tmp[24:0] > {1'b0, i_cfg.ceil_ms}) ? i_cfg.ceil_ms
                                                                      : r_tmp[23:0];
                    r_resent <= 1'b1;
                    if (r_backoff < BACKOFF_LIMIT) begin
                        r_backoff <= r_backoff + 4'd1;
                    end
                end
                UOP_SEND:       r_next <= r_next + {16'd0, i_item.sent_length};
                default: begin
                end
            endcase
        end
    end

    // Status for branch conditions
    always_comb begin
        o_flags.not_adv      = (r_tmp == 32'd0) || r_tmp[SEQ_BITS-1];
        o_flags.tmp_late     = r_tmp[SEQ_BITS-1];
        o_flags.rp_zero      = (r_rp == '0);
        o_flags.srtt_set     = (r_srtt != 24'd0);
        o_flags.cwnd_lt_ssth = (r_cwnd < r_ssth);
        o_flags.div_more     = w_more;
        o_flags.dup_lt3      = (r_dup < DUP_TRIGGER);
    end

    // Present the state as a result item
    always_comb begin
        o_state.congestion_window    = r_cwnd;
        o_state.slow_start_threshold = r_ssth;
        o_state.timeout_ms           = r_rto;
        o_state.smoothed_rtt_ms      = r_srtt;
        o_state.backoff_count        = r_backoff;
        o_state.retransmit_now       = r_resent;
        o_state.in_recovery          = (r_rp != '0);
    end

endmodule

>>> rtl/reno_congestion_rto_controller_top.sv
// Sent events run the shortest program and ACK events the longest one.
// The 32 steps of the radix-2 divider set the longest path.
// One item at a time: a new item is accepted only when idle, once the last result is loaded.
// Reset (synchronous, active low) restores TCP reset state and register defaults at once.
// Top level: handshakes, configuration registers and the microcode sequencer.
module reno_congestion_rto_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rcc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rcc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import rcc_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state    r_state;
    t_uaddr    r_pc;
    t_in_item  r_item;
    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out_data;

    t_uword    w_word;
    t_flags    w_flags;
    t_out_item w_state;
    t_uop      w_op;
    logic      n_jump;
    logic      w_load;

    rcc_ucode_rom u_rom (
        .i_addr (r_pc),
        .o_word (w_word)
    );

    assign w_op = (r_state == S_RUN) ? w_word.op : UOP_NOP;

    rcc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_flags (w_flags),
        .o_state (w_state)
    );

    // Evaluate the branch condition
    always_comb begin
        unique case (w_word.cond)
            C_JUMP:         n_jump = 1'b1;
            C_MODE_SENT:    n_jump = (r_item.mode == MODE_SENT);
            C_MODE_TIMER:   n_jump = (r_item.mode == MODE_TIMER);
            C_MODE_NOT_ACK: n_jump = (r_item.mode != MODE_ACK);
            C_NOT_ADV:      n_jump = w_flags.not_adv;
            C_TMP_LATE:     n_jump = w_flags.tmp_late;
            C_RP_ZERO:      n_jump = w_flags.rp_zero;
            C_NO_RTT:       n_jump = !r_item.rtt_valid;
            C_SRTT_SET:     n_jump = w_flags.srtt_set;
            C_CWND_LT_SSTH: n_jump = w_flags.cwnd_lt_ssth;
            C_DIV_MORE:     n_jump = w_flags.div_more;
            C_DUP_LT3:      n_jump = w_flags.dup_lt3;
            C_NO_QUEUE:     n_jump = !r_item.queue_nonempty;
            default:        n_jump = 1'b0;
        endcase
    end

    // Load the output register at program end once it is free
    assign w_load = (r_state == S_RUN) && (w_word.cond == C_END) &&
                    (!r_out_valid || i_out_ready);

    // Sequencer state, item capture and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_pc    <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_word.cond == C_END) begin
                        // hold until the output register is free
                        if (w_load) begin
                            r_out_data <= w_state;
                            r_state    <= S_IDLE;
                        end
                    end else if (n_jump) begin
                        r_pc <= w_word.target;
                    end else begin
                        r_pc <= r_pc + t_uaddr'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mss      <= MSS_RESET;
            r_cfg.floor_ms <= FLOOR_RESET;
            r_cfg.ceil_ms  <= CEIL_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MSS:   r_cfg.mss      <= i_cfg_data[15:0];
                CFG_FLOOR: r_cfg.floor_ms <= i_cfg_data;
                CFG_CEIL:  r_cfg.ceil_ms  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_backoff_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.backoff_count <= BACKOFF_LIMIT))
        else $error("backoff count above limit");

    a_resend_leaves_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.retransmit_now) |-> !r_out_data.in_recovery)
        else $error("retransmit reported while still in recovery");

    a_resend_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.retransmit_now && !i_cfg_valid)
            |-> (r_out_data.congestion_window == {16'd0, r_cfg.mss}))
        else $error("retransmit without window reset to one segment");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (!o_in_ready && r_pc == '0))
        else $error("sequencer did not start program after accepting an item");
`endif

endmodule

>>> sim/reno_congestion_rto_controller_top_tb.sv
// Self-checking testbench for the Reno congestion window and retransmit timer controller.
module reno_congestion_rto_controller_top_tb;
    import rcc_pkg::*;

    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [1:0]  CFG_UNUSED  = 2'd3;
    localparam logic [31:0] SEQ_HALF    = 32'h8000_0000;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 125;
    localparam int          LONG_HOLD   = 400;
    localparam int          DRAIN_WAIT  = 60;
    localparam int          LIMIT_TIME  = 4_000_000;

    typedef enum {EV_SENT, EV_ACK_NEW, EV_ACK_DUP, EV_TIMER, EV_NOISE} t_stim_kind;

    typedef struct packed {
        logic [1:0]  idx;
        logic [23:0] value;
    } t_reg_write;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    t_out_item   out_data;

    t_in_item    event_q[$];
    t_reg_write  cfg_q[$];
    t_out_item   expected_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_trigger  = 0;
    int stall_seen     = 0;
    int stall_left     = 0;
    int errors         = 0;

    // Shadow of the controller state and its registers
    logic [15:0] mss_cfg   = MSS_RESET;
    logic [23:0] floor_cfg = FLOOR_RESET;
    logic [23:0] ceil_cfg  = CEIL_RESET;
    logic [31:0] win       = CWND_RESET;
    logic [31:0] thresh    = ALL_ONES;
    logic [7:0]  dups      = '0;
    logic [31:0] rec_pt    = '0;
    logic [31:0] una_seq   = '0;
    logic [31:0] snd_nxt   = '0;
    logic [23:0] srtt      = '0;
    logic [23:0] rttvar    = '0;
    logic [23:0] rto       = RTO_RESET;
    logic [3:0]  backoff   = '0;

    // Sequence numbers as the stimulus generator sees them
    logic [31:0] gen_una = '0;
    logic [31:0] gen_nxt = '0;

    reno_congestion_rto_controller_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] clip32(input logic [63:0] v);
        return (v > {32'd0, ALL_ONES}) ? ALL_ONES : v[31:0];
    endfunction

    function automatic logic [31:0] halved_window();
        logic [31:0] half;
        logic [31:0] two_seg;
        half = win >> 1;
        two_seg = {15'd0, mss_cfg, 1'b0};
        return (half > two_seg) ? half : two_seg;
    endfunction

    // Timeout retransmit when data is queued: drop recovery, halve the threshold, collapse the window, double the timer
    function automatic logic timer_backoff(input logic queued);
        logic [31:0] prev;
        if (!queued)
            return 1'b0;
        rec_pt = '0;
        dups = '0;
        thresh = halved_window();
        win = {16'd0, mss_cfg};
        prev = {8'd0, rto};
        if (prev < {8'd0, floor_cfg})
            prev = {8'd0, floor_cfg};
        prev = prev << 1;
        if (prev > {8'd0, ceil_cfg})
            prev = {8'd0, ceil_cfg};
        rto = prev[23:0];
        if (backoff < BACKOFF_LIMIT)
            backoff++;
        return 1'b1;
    endfunction

    // Advance the shadow state by one event and return the state it reports
    function automatic t_out_item reno_advance(input t_in_item ev);
        t_out_item   res;
        logic [31:0] adv;
        logic [31:0] past_rec;
        logic [31:0] delta;
        logic [31:0] margin;
        logic [31:0] sum;
        logic [63:0] wide;
        logic        resent;
        resent = 1'b0;
        case (ev.mode)
            MODE_SENT: begin
                snd_nxt = snd_nxt + {16'd0, ev.sent_length};
            end
            MODE_ACK: begin
                adv = ev.ack_number - una_seq;
                past_rec = ev.ack_number - rec_pt;
                if (adv != 0 && adv < SEQ_HALF) begin
                    // leave recovery once the recovery point is acked
                    if (rec_pt != 0 && past_rec < SEQ_HALF) begin
                        win = thresh;
                        rec_pt = '0;
                        dups = '0;
                    end
                    una_seq = ev.ack_number;
                    if (ev.rtt_valid) begin
                        if (srtt == 0) begin
                            srtt = ev.rtt_sample;
                            rttvar = ev.rtt_sample >> 1;
                        end else begin
                            delta = (ev.rtt_sample >= srtt) ? {8'd0, ev.rtt_sample - srtt}
                                                            : {8'd0, srtt - ev.rtt_sample};
                            sum = 32'd3 * {8'd0, rttvar} + delta;
                            rttvar = sum[25:2];
                            sum = 32'd7 * {8'd0, srtt} + {8'd0, ev.rtt_sample};
                            srtt = sum[26:3];
                        end
                        margin = {6'd0, rttvar, 2'b00};
                        if (margin < {6'd0, RTO_MIN_MARGIN})
                            margin = {6'd0, RTO_MIN_MARGIN};
                        sum = {8'd0, srtt} + margin;
                        if (sum < {8'd0, floor_cfg})
                            sum = {8'd0, floor_cfg};
                        if (sum > {8'd0, ceil_cfg})
                            sum = {8'd0, ceil_cfg};
                        rto = sum[23:0];
                        backoff = '0;
                    end
                    // slow start below the threshold, congestion avoidance above it
                    if (win < thresh) begin
                        wide = {32'd0, win} + {48'd0, mss_cfg};
                        if (wide > {32'd0, thresh})
                            wide = {32'd0, thresh};
                        win = wide[31:0];
                    end else begin
                        wide = {48'd0, mss_cfg} * {48'd0, mss_cfg};
                        wide = wide / ((win == 0) ? 64'd1 : {32'd0, win});
                        win = clip32({32'd0, win} + wide);
                    end
                    dups = '0;
                end else if (rec_pt != 0) begin
                    if (dups < DUP_MAX)
                        dups++;
                    if (dups >= DUP_TRIGGER) begin
                        thresh = halved_window();
                        win = clip32({32'd0, thresh} + 64'd3 * {48'd0, mss_cfg});
                        rec_pt = snd_nxt;
                        resent = timer_backoff(ev.queue_nonempty);
                    end
                end
            end
            MODE_TIMER: begin
                resent = timer_backoff(ev.queue_nonempty);
            end
            default: ; // unused mode only reports the current state
        endcase
        res.congestion_window    = win;
        res.slow_start_threshold = thresh;
        res.timeout_ms           = rto;
        res.smoothed_rtt_ms      = srtt;
        res.backoff_count        = backoff;
        res.retransmit_now       = resent;
        res.in_recovery          = (rec_pt != 0);
        return res;
    endfunction

    function automatic t_in_item pack_event(input logic [1:0] mode, input logic [31:0] ack,
                                            input logic [15:0] len, input logic [23:0] rtt,
                                            input logic rv, input logic queued);
        return '{mode, ack, len, rtt, rv, queued};
    endfunction

    // Build one event of the given kind; fields the kind does not use stay random
    function automatic t_in_item make_event(input t_stim_kind kind);
        t_in_item    ev;
        logic [95:0] raw;
        logic [31:0] outstanding;
        raw = {$urandom, $urandom, $urandom};
        ev = raw[$bits(t_in_item)-1:0];
        ev.queue_nonempty = ($urandom_range(9) < 8);
        outstanding = gen_nxt - gen_una;
        case (kind)
            EV_SENT: begin
                ev.mode = MODE_SENT;
                if ($urandom_range(9) != 0)
                    ev.sent_length = 16'($urandom_range(1, 3000));
            end
            EV_ACK_NEW: begin
                ev.mode = MODE_ACK;
                if (outstanding != 0 && outstanding < SEQ_HALF)
                    ev.ack_number = gen_una + $urandom_range(1, outstanding);
                else
                    ev.ack_number = gen_una + $urandom_range(1, 3000);
                if ($urandom_range(7) != 0)
                    ev.rtt_sample = 24'($urandom_range(1, 2000));
                ev.rtt_valid = ($urandom_range(3) != 0);
            end
            EV_ACK_DUP: begin
                ev.mode = MODE_ACK;
                ev.ack_number = gen_una - $urandom_range(0, 2);
            end
            EV_TIMER: begin
                ev.mode = MODE_TIMER;
            end
            default: ; // fully random item, unused mode included
        endcase
        return ev;
    endfunction

    // Track the sequence space, then hand the item to the driver
    task automatic queue_event(input t_in_item ev);
        logic [31:0] adv;
        adv = ev.ack_number - gen_una;
        if (ev.mode == MODE_SENT)
            gen_nxt = gen_nxt + {16'd0, ev.sent_length};
        else if (ev.mode == MODE_ACK && adv != 0 && adv < SEQ_HALF)
            gen_una = ev.ack_number;
        event_q.push_back(ev);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (event_q.size() != 0 || cfg_q.size() != 0 || in_valid || cfg_valid ||
               expected_q.size() != 0);
    endtask

    // Event driver: present queued items, predict each accepted one
    always @(posedge clk) begin : event_driver
        logic offer;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offer = in_valid;
            if (in_valid && in_ready) begin
                expected_q.push_back(reno_advance(in_data));
                offer = 1'b0;
            end
            if (!offer && event_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_data <= event_q.pop_front();
                offer = 1'b1;
            end
            in_valid <= offer;
        end
    end

    // Register writer: apply each accepted write to the shadow registers
    always @(posedge clk) begin : reg_writer
        logic offer;
        if (!rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            offer = cfg_valid;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MSS:   mss_cfg = cfg_data[15:0];
                    CFG_FLOOR: floor_cfg = cfg_data;
                    CFG_CEIL:  ceil_cfg = cfg_data;
                    default:   ; // unused index, write is dropped
                endcase
                offer = 1'b0;
            end
            if (!offer && cfg_q.size() > 0) begin
                {cfg_index, cfg_data} <= cfg_q.pop_front();
                offer = 1'b1;
            end
            cfg_valid <= offer;
        end
    end

    // Long receiver hold-off, started on request
    always @(posedge clk) begin : hold_counter
        if (!rst_n) begin
            stall_left <= 0;
        end else if (stall_seen != stall_trigger) begin
            stall_seen <= stall_trigger;
            stall_left <= LONG_HOLD;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk) begin : result_monitor
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with no prediction pending: %p", out_data);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("congestion_window", want.congestion_window,
                                out_data.congestion_window);
                    check_field("slow_start_threshold", want.slow_start_threshold,
                                out_data.slow_start_threshold);
                    check_field("timeout_ms", want.timeout_ms, out_data.timeout_ms);
                    check_field("smoothed_rtt_ms", want.smoothed_rtt_ms,
                                out_data.smoothed_rtt_ms);
                    check_field("backoff_count", want.backoff_count, out_data.backoff_count);
                    check_field("retransmit_now", want.retransmit_now, out_data.retransmit_now);
                    check_field("in_recovery", want.in_recovery, out_data.in_recovery);
                end
            end
            out_ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stimulus
        t_in_item    ev;
        t_stim_kind  kind;
        int          pick;
        logic [23:0] mss_w;
        logic [23:0] floor_w;
        logic [23:0] ceil_w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: length extremes, sample extremes, non-advancing ACKs, unused mode
        queue_event(pack_event(MODE_SENT, '0, 16'd0, '0, 1'b0, 1'b0));
        queue_event(pack_event(MODE_SENT, '1, 16'hFFFF, '1, 1'b1, 1'b1));
        queue_event(pack_event(MODE_SENT, '0, 16'd1460, '0, 1'b0, 1'b0));
        queue_event(pack_event(MODE_ACK, 32'd1000, '0, 24'hFFFFFF, 1'b1, 1'b0));
        queue_event(pack_event(MODE_ACK, 32'd2000, '0, 24'd0, 1'b1, 1'b0));
        queue_event(pack_event(MODE_ACK, 32'd2000, '1, 24'd50, 1'b1, 1'b1));
        queue_event(pack_event(MODE_ACK, 32'hFFFF_FFFF, '0, 24'd50, 1'b1, 1'b1));
        queue_event(pack_event(MODE_ACK, 32'd2000 + SEQ_HALF, '0, 24'd50, 1'b1, 1'b0));
        queue_event(pack_event(MODE_UNUSED, '1, '1, '1, 1'b1, 1'b1));
        queue_event(pack_event(MODE_TIMER, '0, '0, '0, 1'b0, 1'b0));
        // run the backoff count into its cap
        repeat (14)
            queue_event(pack_event(MODE_TIMER, '1, '0, '1, 1'b1, 1'b1));
        queue_event(pack_event(MODE_ACK, 32'd2000 + SEQ_HALF - 1, '0, 24'd300, 1'b0, 1'b0));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin mss_w = 24'd1460;   floor_w = 24'd200;     ceil_w = 24'd60000;    end
                1: begin mss_w = 24'd1;      floor_w = 24'd1;       ceil_w = 24'd1;        end
                2: begin mss_w = 24'd65535;  floor_w = 24'hFFFFFF;  ceil_w = 24'hFFFFFF;   end
                // floor above ceiling: the ceiling wins
                3: begin mss_w = 24'd536;    floor_w = 24'd5000;    ceil_w = 24'd300;      end
                // upper bits dropped, segment size becomes zero
                4: begin mss_w = 24'h010000; floor_w = 24'd1;       ceil_w = 24'hFFFFFF;   end
                5: begin mss_w = 24'd9000;   floor_w = 24'd100;     ceil_w = 24'd120000;   end
                default: begin
                    mss_w = 24'($urandom);
                    floor_w = 24'($urandom_range(1, 3000));
                    ceil_w = 24'($urandom_range(1, 24'hFFFFFF));
                end
            endcase
            cfg_q.push_back('{CFG_MSS, mss_w});
            cfg_q.push_back('{CFG_FLOOR, floor_w});
            cfg_q.push_back('{CFG_CEIL, ceil_w});
            cfg_q.push_back('{CFG_UNUSED, 24'($urandom)});
            wait_drained();

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase

            // two queued timeouts then a new ACK: zero threshold when the segment is zero
            repeat (2) begin
                ev = make_event(EV_TIMER);
                ev.queue_nonempty = 1'b1;
                queue_event(ev);
            end
            queue_event(make_event(EV_ACK_NEW));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                kind = (pick < 35) ? EV_SENT :
                       (pick < 72) ? EV_ACK_NEW :
                       (pick < 84) ? EV_ACK_DUP :
                       (pick < 92) ? EV_TIMER : EV_NOISE;
                queue_event(make_event(kind));
            end
            // back up the output while the sender keeps offering
            if (p == 0)
                stall_trigger++;
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("reno_congestion_rto_controller_top_tb passed");
        else
            $display("reno_congestion_rto_controller_top_tb failed");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_TIME);
        $display("reno_congestion_rto_controller_top_tb failed");
        $finish;
    end

endmodule
